[hdl/quadrature_encoder_angle_tracker_defines.svh]
// assertion macros shared by the checker
`ifndef QUADRATURE_ENCODER_ANGLE_TRACKER_DEFINES_SVH
`define QUADRATURE_ENCODER_ANGLE_TRACKER_DEFINES_SVH

// same-cycle implication
`define QEAT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qeat check failed");

// next-cycle implication
`define QEAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qeat check failed");

`endif

[hdl/qeat_pkg.sv]
`timescale 1ns / 1ps
package qeat_pkg;

  localparam int ResW    = 16;
  localparam int PeriodW = 17;
  localparam int CountW  = 16;
  localparam int StepW   = 19;
  localparam int TurnW   = 32;
  localparam int RevW    = 16;
  localparam int AngW    = 25;
  localparam int TotalW  = 41;
  localparam int OutStepW = 17;

  localparam logic [AngW-1:0] Deg360Q16 = 25'd23592960;
  localparam logic [8:0]      Deg360    = 9'd360;

  localparam logic REQ_COUNTER = 1'b0;
  localparam logic REQ_EDGE    = 1'b1;
  localparam logic PIN_A       = 1'b0;
  localparam logic PIN_B       = 1'b1;

  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] REG_RESOLUTION = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_PERIOD     = 1'b1;

  localparam logic [ResW-1:0]    ResolutionReset = 16'd4096;
  localparam logic [PeriodW-1:0] PeriodReset     = 17'd65536;

  localparam logic [1:0] PH_A1B0 = 2'd0;
  localparam logic [1:0] PH_A0B0 = 2'd1;
  localparam logic [1:0] PH_A0B1 = 2'd2;
  localparam logic [1:0] PH_A1B1 = 2'd3;

  localparam int DivSteps = 25;
  localparam int DivCntW  = $clog2(DivSteps);

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[hdl/qeat_step.sv]
`timescale 1ns / 1ps
module qeat_step (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           req_type,
  input  logic [qeat_pkg::CountW-1:0]    counter_value,
  input  logic                           pin_select,
  input  logic                           pin_level,
  input  logic [qeat_pkg::PeriodW-1:0]   counter_period,
  output logic signed [qeat_pkg::StepW-1:0] step
);
  import qeat_pkg::*;

  logic [CountW-1:0] last_count;
  logic [1:0]        quad_phase;
  logic [1:0]        phase_next;
  logic signed [StepW-1:0] edge_step;
  logic signed [StepW-1:0] diff;
  logic signed [StepW-1:0] diff_next;
  logic                    is_edge;
  logic signed [StepW-1:0] half;
  logic signed [StepW-1:0] period;

  // quadrature decoder transition
  always_comb begin
    phase_next = quad_phase;
    edge_step  = '0;
    case ({pin_select, pin_level})
      {PIN_A, 1'b1}: begin
        if (quad_phase == PH_A0B0) begin
          phase_next = PH_A1B0;
          edge_step  = -19'sd1;
        end else if (quad_phase == PH_A0B1) begin
          phase_next = PH_A1B1;
          edge_step  = 19'sd1;
        end
      end
      {PIN_A, 1'b0}: begin
        if (quad_phase == PH_A1B0) begin
          phase_next = PH_A0B0;
          edge_step  = 19'sd1;
        end else if (quad_phase == PH_A1B1) begin
          phase_next = PH_A0B1;
          edge_step  = -19'sd1;
        end
      end
      {PIN_B, 1'b1}: begin
        if (quad_phase == PH_A1B0) begin
          phase_next = PH_A1B1;
          edge_step  = -19'sd1;
        end else if (quad_phase == PH_A0B0) begin
          phase_next = PH_A0B1;
          edge_step  = 19'sd1;
        end
      end
      {PIN_B, 1'b0}: begin
        if (quad_phase == PH_A0B1) begin
          phase_next = PH_A0B0;
          edge_step  = -19'sd1;
        end else if (quad_phase == PH_A1B1) begin
          phase_next = PH_A1B0;
          edge_step  = 19'sd1;
        end
      end
      default: begin
        phase_next = quad_phase;
        edge_step  = '0;
      end
    endcase
  end

  assign diff_next = $signed({3'b000, counter_value}) - $signed({3'b000, last_count});

  always_ff @(posedge clk) begin
    if (rst) begin
      last_count <= '0;
      quad_phase <= PH_A1B0;
      is_edge    <= 1'b0;
      diff       <= '0;
    end else if (accept) begin
      is_edge <= (req_type == REQ_EDGE);
      if (req_type == REQ_EDGE) begin
        quad_phase <= phase_next;
        diff       <= edge_step;
      end else begin
        last_count <= counter_value;
        diff       <= diff_next;
      end
    end
  end

  // counter wrap correction
  assign half   = $signed({3'b000, counter_period[PeriodW-1:1]});
  assign period = $signed({2'b00, counter_period});

  always_comb begin
    if (is_edge) begin
      step = diff;
    end else if (diff > half) begin
      step = diff - period;
    end else if (diff < -half) begin
      step = diff + period;
    end else begin
      step = diff;
    end
  end

endmodule

[hdl/qeat_div.sv]
`timescale 1ns / 1ps
module qeat_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [qeat_pkg::ResW-1:0]   count,
  input  logic [qeat_pkg::ResW-1:0]   divisor,
  output logic [qeat_pkg::AngW-1:0]   quotient,
  output qeat_pkg::div_stat_t         stat
);
  import qeat_pkg::*;

  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivSteps - 1);
  localparam int LowW = AngW - ResW;

  logic [AngW-1:0]    prod;
  logic [ResW-1:0]    rem;
  logic [AngW-1:0]    dividend;
  logic [DivCntW-1:0] cnt;
  logic [ResW+1:0]    trial;
  logic               fits;

  // count * 360, then shifted left by 16 as the dividend
  assign prod  = AngW'(count) * AngW'(Deg360);
  assign trial = {1'b0, rem, dividend[AngW-1]} - {2'b00, divisor};
  assign fits  = ~trial[ResW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= stat.busy & ~start & (cnt == DivLast);
      if (start) begin
        rem       <= prod[AngW-1:LowW];
        dividend  <= {prod[LowW-1:0], {ResW{1'b0}}};
        cnt       <= '0;
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        rem      <= fits ? trial[ResW-1:0] : {rem[ResW-2:0], dividend[AngW-1]};
        dividend <= {dividend[AngW-2:0], 1'b0};
        quotient <= {quotient[AngW-2:0], fits};
        cnt      <= cnt + DivCntW'(1);
        if (cnt == DivLast) begin
          stat.busy <= 1'b0;
        end
      end
    end
  end

endmodule

[hdl/quadrature_encoder_angle_tracker.sv]
`timescale 1ns / 1ps
// channel      direction  handshake                     payload
// s_axis       in         s_axis_tvalid / s_axis_tready tdata, tuser
// m_axis       out        m_axis_tvalid / m_axis_tready tdata
// cfg          in         cfg_write (no wait)           cfg_index, cfg_data
//
// an item passes through the step, add, fold, prep, divide and output states
// before its result is offered; no new item is taken until the block is back
// in idle, and a bit-serial divider forms the angle within the turn
// reset is synchronous; no memory needs clearing
// the result waits in the output register while the next item is accepted;
// the block holds in its last step until that register is free
module quadrature_encoder_angle_tracker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [23:0]                      s_axis_tdata,  // counter_value, pin_level
  input  logic [1:0]                       s_axis_tuser,  // req_type, pin_select
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // step_delta, position_in_turn, revolutions, angle_in_turn, abs_angle
  output logic [119:0]                     m_axis_tdata,
  input  logic                             cfg_write,
  input  logic [qeat_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [qeat_pkg::PeriodW-1:0]     cfg_data
);
  import qeat_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STEP = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_FOLD = 3'd3;
  localparam logic [2:0] S_PREP = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]          state;
  logic [ResW-1:0]     resolution;
  logic [PeriodW-1:0]  counter_period;
  logic [ResW-1:0]     res_eff;
  logic [TurnW-1:0]    turn_count;
  logic [RevW-1:0]     round_count;
  logic signed [StepW-1:0] step;
  logic signed [StepW-1:0] step_q;
  logic [TurnW-1:0]    tc_raw;
  logic [TurnW-1:0]    res_wide;
  logic [CountW-1:0]   pos_q;
  logic                ang_zero;
  logic                ang_full;
  logic signed [AngW-1:0] rev360;
  logic [AngW-1:0]     quotient;
  logic [AngW-1:0]     ang;
  logic [TotalW-1:0]   total;
  logic                accept;
  logic                out_free;
  div_stat_t           div_stat;

  assign accept        = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = ~m_axis_tvalid | m_axis_tready;
  assign res_eff       = (resolution == '0) ? ResW'(1) : resolution;
  assign res_wide      = {{(TurnW - ResW){1'b0}}, res_eff};

  qeat_step u_step (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .req_type       (s_axis_tuser[0]),
    .counter_value  (s_axis_tdata[15:0]),
    .pin_select     (s_axis_tuser[1]),
    .pin_level      (s_axis_tdata[16]),
    .counter_period (counter_period),
    .step           (step)
  );

  qeat_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_PREP),
    .count    (turn_count[ResW-1:0]),
    .divisor  (res_eff),
    .quotient (quotient),
    .stat     (div_stat)
  );

  assign ang   = ang_zero ? '0 : (ang_full ? Deg360Q16 : quotient);
  assign total = $signed({rev360, {CountW{1'b0}}}) + $signed({{(TotalW - AngW){1'b0}}, ang});

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution     <= ResolutionReset;
      counter_period <= PeriodReset;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RESOLUTION: resolution     <= cfg_data[ResW-1:0];
        REG_PERIOD:     counter_period <= cfg_data;
        default:        resolution     <= resolution;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      turn_count    <= '0;
      round_count   <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if ((state == S_OUT) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          step_q <= step;
          state  <= S_ADD;
        end
        S_ADD: begin
          tc_raw <= turn_count + {{(TurnW - StepW){step_q[StepW-1]}}, step_q};
          state  <= S_FOLD;
        end
        S_FOLD: begin
          if ($signed(tc_raw) > $signed(res_wide)) begin
            turn_count  <= tc_raw - res_wide;
            round_count <= round_count + RevW'(1);
          end else if (tc_raw[TurnW-1]) begin
            turn_count  <= tc_raw + res_wide;
            round_count <= round_count - RevW'(1);
          end else begin
            turn_count <= tc_raw;
          end
          state <= S_PREP;
        end
        S_PREP: begin
          if (turn_count[TurnW-1]) begin
            pos_q <= '0;
          end else if (turn_count[TurnW-2:CountW] != '0) begin
            pos_q <= '1;
          end else begin
            pos_q <= turn_count[CountW-1:0];
          end
          ang_zero <= turn_count[TurnW-1] | (turn_count == '0);
          ang_full <= $signed(turn_count) >= $signed(res_wide);
          rev360   <= $signed({{(AngW - RevW){round_count[RevW-1]}}, round_count}) *
                      $signed({{(AngW - 9){1'b0}}, Deg360});
          state    <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            m_axis_tdata  <= {5'b00000, total, ang, round_count, pos_q,
                              step_q[OutStepW-1:0]};
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/qeat_checker.sv]
`timescale 1ns / 1ps
`include "quadrature_encoder_angle_tracker_defines.svh"
module qeat_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [119:0] m_axis_tdata
);

  `QEAT_ASSERT_NEXT(out_valid_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `QEAT_ASSERT_NEXT(out_data_holds, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `QEAT_ASSERT_NEXT(busy_after_request, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `QEAT_ASSERT_IMPL(angle_in_range, m_axis_tvalid, m_axis_tdata[73:49] <= 25'd23592960)
  `QEAT_ASSERT_IMPL(angle_tracks_position, m_axis_tvalid,
                    (m_axis_tdata[32:17] == 16'd0) == (m_axis_tdata[73:49] == 25'd0))

endmodule

bind quadrature_encoder_angle_tracker qeat_checker u_qeat_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
